// File: rtl/core/gcr_sector_data_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// gcr_sector_data_encoder_core_defines
// assertion macros of the encoder core
// ----------------------------------------------------------------------------
`ifndef GCR_SECTOR_DATA_ENCODER_CORE_DEFINES_SVH
`define GCR_SECTOR_DATA_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GCRE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gcre assertion failed");

// next-cycle implication, checked out of reset
`define GCRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gcre assertion failed");

`endif

// File: rtl/core/gcre_pkg.sv
// ----------------------------------------------------------------------------
// gcre_pkg
// types, constants and the 6-and-2 code table of the sector data encoder
// ----------------------------------------------------------------------------
package gcre_pkg;

    localparam int MaxCodes = 9;
    localparam int IdxW     = $clog2(MaxCodes);

    localparam logic [9:0] LastByte = 10'd523;

    localparam logic [7:0] MarkD5 = 8'hD5;
    localparam logic [7:0] MarkAA = 8'hAA;
    localparam logic [7:0] MarkAD = 8'hAD;
    localparam logic [7:0] MarkDE = 8'hDE;

    localparam logic [IdxW-1:0] CountGroup = IdxW'(4);
    localparam logic [IdxW-1:0] CountTail  = IdxW'(MaxCodes);

    // byte position within a group of three
    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } t_phase;

    // all words caused by one input byte
    typedef struct packed {
        logic [MaxCodes-1:0][7:0] codes;
        logic [IdxW-1:0]          count;
        logic                     done;
    } t_packet;

    function automatic logic [7:0] code6(input logic [5:0] v);
        logic [7:0] c;
        case (v)
            6'd0:  c = 8'h96;  6'd1:  c = 8'h97;  6'd2:  c = 8'h9A;  6'd3:  c = 8'h9B;
            6'd4:  c = 8'h9D;  6'd5:  c = 8'h9E;  6'd6:  c = 8'h9F;  6'd7:  c = 8'hA6;
            6'd8:  c = 8'hA7;  6'd9:  c = 8'hAB;  6'd10: c = 8'hAC;  6'd11: c = 8'hAD;
            6'd12: c = 8'hAE;  6'd13: c = 8'hAF;  6'd14: c = 8'hB2;  6'd15: c = 8'hB3;
            6'd16: c = 8'hB4;  6'd17: c = 8'hB5;  6'd18: c = 8'hB6;  6'd19: c = 8'hB7;
            6'd20: c = 8'hB9;  6'd21: c = 8'hBA;  6'd22: c = 8'hBB;  6'd23: c = 8'hBC;
            6'd24: c = 8'hBD;  6'd25: c = 8'hBE;  6'd26: c = 8'hBF;  6'd27: c = 8'hCB;
            6'd28: c = 8'hCD;  6'd29: c = 8'hCE;  6'd30: c = 8'hCF;  6'd31: c = 8'hD3;
            6'd32: c = 8'hD6;  6'd33: c = 8'hD7;  6'd34: c = 8'hD9;  6'd35: c = 8'hDA;
            6'd36: c = 8'hDB;  6'd37: c = 8'hDC;  6'd38: c = 8'hDD;  6'd39: c = 8'hDE;
            6'd40: c = 8'hDF;  6'd41: c = 8'hE5;  6'd42: c = 8'hE6;  6'd43: c = 8'hE7;
            6'd44: c = 8'hE9;  6'd45: c = 8'hEA;  6'd46: c = 8'hEB;  6'd47: c = 8'hEC;
            6'd48: c = 8'hED;  6'd49: c = 8'hEE;  6'd50: c = 8'hEF;  6'd51: c = 8'hF2;
            6'd52: c = 8'hF3;  6'd53: c = 8'hF4;  6'd54: c = 8'hF5;  6'd55: c = 8'hF6;
            6'd56: c = 8'hF7;  6'd57: c = 8'hF9;  6'd58: c = 8'hFA;  6'd59: c = 8'hFB;
            6'd60: c = 8'hFC;  6'd61: c = 8'hFD;  6'd62: c = 8'hFE;  6'd63: c = 8'hFF;
            default: c = 8'h96;
        endcase
        return c;
    endfunction

    // top two bits of each of three bytes, packed into one six-bit value
    function automatic logic [5:0] top_bits(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        return {a[7:6], b[7:6], c[7:6]};
    endfunction

endpackage

// File: rtl/core/gcre_in_if.sv
// ----------------------------------------------------------------------------
// gcre_in_if
// input channel of the encoder: one sector byte per word
// ----------------------------------------------------------------------------
interface gcre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [5:0] sector_number;

    modport source (output valid, output data_byte, output sector_number, input ready);
    modport sink   (input valid, input data_byte, input sector_number, output ready);
endinterface

// File: rtl/core/gcre_out_if.sv
// ----------------------------------------------------------------------------
// gcre_out_if
// output channel of the encoder: one disk nibble per word
// ----------------------------------------------------------------------------
interface gcre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       run_last;
    logic       sector_done;

    modport source (output valid, output code_byte, output run_last, output sector_done,
                    input ready);
    modport sink   (input valid, input code_byte, input run_last, input sector_done,
                    output ready);
endinterface

// File: rtl/core/gcre_serializer.sv
// ----------------------------------------------------------------------------
// gcre_serializer
// holds the words of one input byte and sends them out one per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module gcre_serializer
    import gcre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_packet     i_pkt,
    output logic        o_can_load,
    gcre_out_if.source  o_out
);

    logic            r_valid;
    logic [IdxW-1:0] r_idx;
    t_packet         r_pkt;

    logic            w_pop;
    logic            w_last;

    assign w_last     = r_idx == (r_pkt.count - IdxW'(1));
    assign w_pop      = r_valid && o_out.ready;
    assign o_can_load = !r_valid || (w_pop && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (w_pop) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IdxW'(1);
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pkt <= i_pkt;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.code_byte   = r_pkt.codes[r_idx];
    assign o_out.run_last    = w_last;
    assign o_out.sector_done = r_pkt.done && w_last;

endmodule

// File: rtl/core/gcr_sector_data_encoder_core.sv
// ----------------------------------------------------------------------------
// gcr_sector_data_encoder_core
// 6-and-2 gcr data field encoder with triple rolling checksum
// ----------------------------------------------------------------------------
// usage
//   i_in takes the 524 bytes of a sector (tags first, then data), one per word;
//   sector_number is sampled on the first byte of each sector only
//   o_out gives the 709 disk nibbles of the data field, one per word: the
//   mark D5 AA AD and coded sector number, four nibbles per group of three
//   bytes, then the last short group, four checksum nibbles and DE AA
//   run_last flags the final nibble caused by a byte, sector_done the closing AA
// order and throughput
//   a byte that causes nibbles shows its first nibble in the cycle after it is
//   accepted; its 4 or 9 nibbles leave at one per cycle from the result register
//   while the receiver is ready; bytes that cause no nibble are taken every cycle,
//   even while nibbles drain; a byte that causes nibbles waits only until the
//   last pending nibble leaves
// reset and stalls
//   reset clears the position, the checksums and the valid flag of the result
//   register; the next byte starts a new sector
//   when the receiver stalls the result register holds and i_in.ready drops
//   for the next byte that would cause nibbles
// ----------------------------------------------------------------------------
`include "gcr_sector_data_encoder_core_defines.svh"

module gcr_sector_data_encoder_core
    import gcre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcre_in_if.sink    i_in,
    gcre_out_if.source o_out
);

    // sector state
    logic [9:0] r_pos;
    t_phase     r_phase;
    logic [7:0] r_rot;
    logic [8:0] r_mid;
    logic [8:0] r_first;
    logic [7:0] r_h1;
    logic [7:0] r_h2;

    logic [9:0] n_pos;
    t_phase     n_phase;
    logic [7:0] n_rot;
    logic [8:0] n_mid;
    logic [8:0] n_first;
    logic [7:0] n_h1;
    logic [7:0] n_h2;

    // checksums as seen by this byte, cleared at sector start
    logic [7:0] s_rot;
    logic [8:0] s_mid;
    logic [8:0] s_first;

    logic       w_first_byte;
    logic       w_last_byte;
    logic       w_emits;
    logic       w_fire;
    logic       w_load;
    logic       w_can_load;
    logic [7:0] w_byte;
    logic [7:0] w_rot_l;
    logic [7:0] w_third;
    t_packet    w_pkt;

    assign w_byte       = i_in.data_byte;
    assign w_first_byte = r_pos == '0;
    assign w_last_byte  = r_pos == LastByte;
    assign w_emits      = w_first_byte || w_last_byte || (r_phase == PH_THIRD);

    // a byte with no nibbles never has to wait for the output side
    assign i_in.ready = w_can_load || !w_emits;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_load     = w_fire && w_emits;

    assign s_rot   = w_first_byte ? '0 : r_rot;
    assign s_mid   = w_first_byte ? '0 : r_mid;
    assign s_first = w_first_byte ? '0 : r_first;

    assign w_rot_l = {s_rot[6:0], s_rot[7]};
    assign w_third = w_byte ^ s_mid[7:0];

    // checksum and whitening update
    always_comb begin
        n_rot   = s_rot;
        n_mid   = s_mid;
        n_first = s_first;
        n_h1    = r_h1;
        n_h2    = r_h2;
        case (r_phase)
            PH_FIRST: begin
                n_rot   = w_rot_l;
                n_h1    = w_byte ^ w_rot_l;
                n_first = {1'b0, s_first[7:0]} + {1'b0, w_byte} + {8'b0, w_rot_l[0]};
            end
            PH_SECOND: begin
                n_h2    = w_byte ^ s_first[7:0];
                n_mid   = {1'b0, s_mid[7:0]} + {1'b0, w_byte} + {8'b0, s_first[8]};
                n_first = {1'b0, s_first[7:0]};
                // carry out of the last group is dropped
                if (w_last_byte) begin
                    n_mid[8] = 1'b0;
                end
            end
            PH_THIRD: begin
                n_rot = s_rot + w_byte + {7'b0, s_mid[8]};
                n_mid = {1'b0, s_mid[7:0]};
            end
            default: begin
                n_rot = s_rot;
            end
        endcase
    end

    // words caused by this byte
    always_comb begin
        w_pkt = '0;
        if (w_first_byte) begin
            w_pkt.codes[0] = MarkD5;
            w_pkt.codes[1] = MarkAA;
            w_pkt.codes[2] = MarkAD;
            w_pkt.codes[3] = code6(i_in.sector_number);
            w_pkt.count    = CountGroup;
        end else if (w_last_byte) begin
            w_pkt.codes[0] = code6(top_bits(r_h1, n_h2, 8'h00));
            w_pkt.codes[1] = code6(r_h1[5:0]);
            w_pkt.codes[2] = code6(n_h2[5:0]);
            w_pkt.codes[3] = code6(top_bits(n_first[7:0], n_mid[7:0], n_rot));
            w_pkt.codes[4] = code6(n_first[5:0]);
            w_pkt.codes[5] = code6(n_mid[5:0]);
            w_pkt.codes[6] = code6(n_rot[5:0]);
            w_pkt.codes[7] = MarkDE;
            w_pkt.codes[8] = MarkAA;
            w_pkt.count    = CountTail;
            w_pkt.done     = 1'b1;
        end else if (r_phase == PH_THIRD) begin
            w_pkt.codes[0] = code6(top_bits(r_h1, r_h2, w_third));
            w_pkt.codes[1] = code6(r_h1[5:0]);
            w_pkt.codes[2] = code6(r_h2[5:0]);
            w_pkt.codes[3] = code6(w_third[5:0]);
            w_pkt.count    = CountGroup;
        end
    end

    // position and group phase, wrapping at the end of the sector
    always_comb begin
        if (w_last_byte) begin
            n_pos   = '0;
            n_phase = PH_FIRST;
        end else begin
            n_pos = r_pos + 10'd1;
            case (r_phase)
                PH_FIRST:  n_phase = PH_SECOND;
                PH_SECOND: n_phase = PH_THIRD;
                PH_THIRD:  n_phase = PH_FIRST;
                default:   n_phase = PH_FIRST;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_FIRST;
            r_rot   <= '0;
            r_mid   <= '0;
            r_first <= '0;
            r_h1    <= '0;
            r_h2    <= '0;
        end else if (w_fire) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_rot   <= n_rot;
            r_mid   <= n_mid;
            r_first <= n_first;
            r_h1    <= n_h1;
            r_h2    <= n_h2;
        end
    end

    // result register and nibble sequencing
    gcre_serializer u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_pkt      (w_pkt),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

    // sector start is always the first byte of a group
    `GCRE_ASSERT_IMPL(a_start_phase, i_clk, i_rst_n, r_pos == '0, r_phase == PH_FIRST)
    // the closing byte wraps to a fresh sector
    `GCRE_ASSERT_NEXT(a_wrap, i_clk, i_rst_n, w_fire && w_last_byte,
                      r_pos == '0 && r_phase == PH_FIRST)
    // a byte that causes nibbles has them waiting in the next cycle
    `GCRE_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load, o_out.valid)
    // the closing mark ends the run of its byte
    `GCRE_ASSERT_IMPL(a_done_last, i_clk, i_rst_n, o_out.valid && o_out.sector_done,
                      o_out.run_last && o_out.code_byte == MarkAA)

endmodule
